// ===== hw/rtl/particle_circle_reflect_top_assert.svh =====
// Assertion macros for the particle circle reflect block.
// Used by particle_circle_reflect_top; expects clk and arst_n in scope.
`ifndef PARTICLE_CIRCLE_REFLECT_TOP_ASSERT_SVH
`define PARTICLE_CIRCLE_REFLECT_TOP_ASSERT_SVH

// same-cycle implication
`define PCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pcr_pkg.sv =====
// Package for the particle circle reflect block: widths, register indexes,
// pipeline carry types and saturation helpers. No dependencies.
package pcr_pkg;

	localparam int POS_W     = 20;
	localparam int VEL_W     = 17;
	localparam int DT_W      = 16;
	localparam int PR_W      = 16;
	localparam int CR_W      = 18;
	localparam int CFG_W     = 18;
	localparam int IDX_W     = 4;
	localparam int MOV_W     = 21;
	localparam int DIF_W     = 22;
	localparam int RAD_W     = 44;
	localparam int ROOT_W    = 22;
	localparam int SQ_STEPS  = 22;
	localparam int NUM_W     = 38;
	localparam int Q_W       = 17;
	localparam int DIV_STEPS = 17;
	localparam int N_W       = 18;
	localparam int OV_W      = 24;
	localparam int PW_W      = 28;
	localparam int VW_W      = 22;

	localparam logic [PR_W-1:0] PR_RESET = 16'd1280;
	localparam logic [CR_W-1:0] CR_RESET = 18'd25600;

	typedef enum logic [IDX_W-1:0] {
		REG_PART_RAD         = 4'd0,
		REG_CONTAINER_RADIUS = 4'd1
	} reg_idx_t;

	typedef struct packed {
		logic signed [MOV_W-1:0] px;
		logic signed [MOV_W-1:0] py;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [DIF_W-1:0] dx;
		logic signed [DIF_W-1:0] dy;
	} carry_t;

	typedef struct packed {
		logic signed [MOV_W-1:0] px;
		logic signed [MOV_W-1:0] py;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [OV_W-1:0]  ov;
		logic                    coll;
		logic                    sx;
		logic                    sy;
	} mid_t;

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [PW_W-1:0] v);
		logic signed [PW_W-1:0] hi;
		logic signed [PW_W-1:0] lo;
		hi = PW_W'((64'sd1 <<< (POS_W-1)) - 64'sd1);
		lo = -hi - PW_W'(1);
		if (v > hi) return hi[POS_W-1:0];
		if (v < lo) return lo[POS_W-1:0];
		return v[POS_W-1:0];
	endfunction

	function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VW_W-1:0] v);
		logic signed [VW_W-1:0] hi;
		logic signed [VW_W-1:0] lo;
		hi = VW_W'((64'sd1 <<< (VEL_W-1)) - 64'sd1);
		lo = -hi - VW_W'(1);
		if (v > hi) return hi[VEL_W-1:0];
		if (v < lo) return lo[VEL_W-1:0];
		return v[VEL_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/pcr_if.sv =====
// Stream interfaces for the particle circle reflect block.
// Depends on pcr_pkg for field widths.
interface pcr_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [pcr_pkg::POS_W-1:0] pos_x;
	logic signed [pcr_pkg::POS_W-1:0] pos_y;
	logic signed [pcr_pkg::VEL_W-1:0] vel_x;
	logic signed [pcr_pkg::VEL_W-1:0] vel_y;
	logic        [pcr_pkg::DT_W-1:0]  time_step;
	logic signed [pcr_pkg::POS_W-1:0] center_x;
	logic signed [pcr_pkg::POS_W-1:0] center_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, time_step, center_x, center_y,
		input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, time_step, center_x, center_y,
		output ready);
endinterface

interface pcr_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [pcr_pkg::POS_W-1:0] new_pos_x;
	logic signed [pcr_pkg::POS_W-1:0] new_pos_y;
	logic signed [pcr_pkg::VEL_W-1:0] new_vel_x;
	logic signed [pcr_pkg::VEL_W-1:0] new_vel_y;
	logic                             hit;

	modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, hit,
		input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, hit,
		output ready);
endinterface

// ===== hw/rtl/pcr_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on pcr_pkg for widths and stage count.
module pcr_isqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [pcr_pkg::RAD_W-1:0]    rad,
	output logic [pcr_pkg::ROOT_W-1:0]   root
);
	localparam int RW = pcr_pkg::RAD_W + 1;

	logic [pcr_pkg::RAD_W-1:0] rem_s [pcr_pkg::SQ_STEPS];
	logic [RW-1:0]             rt_s  [pcr_pkg::SQ_STEPS];

	for (genvar gk = 0; gk < pcr_pkg::SQ_STEPS; gk++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (pcr_pkg::SQ_STEPS - 1 - gk));
		logic [pcr_pkg::RAD_W-1:0] vin;
		logic [RW-1:0]             rin;
		logic [RW-1:0]             t;
		if (gk == 0) begin : g_first
			assign vin = rad;
			assign rin = '0;
		end else begin : g_next
			assign vin = rem_s[gk-1];
			assign rin = rt_s[gk-1];
		end
		assign t = rin + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, vin} >= t) begin
					rem_s[gk] <= vin - t[pcr_pkg::RAD_W-1:0];
					rt_s[gk]  <= (rin >> 1) + BIT;
				end else begin
					rem_s[gk] <= vin;
					rt_s[gk]  <= rin >> 1;
				end
			end
		end
	end

	assign root = rt_s[pcr_pkg::SQ_STEPS-1][pcr_pkg::ROOT_W-1:0];
endmodule

// ===== hw/rtl/pcr_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pcr_pkg for widths and stage count.
module pcr_udiv (
	input  logic                        clk,
	input  logic                        en,
	input  logic [pcr_pkg::NUM_W-1:0]   num,
	input  logic [pcr_pkg::ROOT_W-1:0]  den,
	output logic [pcr_pkg::Q_W-1:0]     quo
);
	localparam int DW = pcr_pkg::NUM_W + 1;

	logic [pcr_pkg::NUM_W-1:0]  rem_s [pcr_pkg::DIV_STEPS];
	logic [pcr_pkg::ROOT_W-1:0] den_s [pcr_pkg::DIV_STEPS];
	logic [pcr_pkg::Q_W-1:0]    q_s   [pcr_pkg::DIV_STEPS];

	for (genvar gk = 0; gk < pcr_pkg::DIV_STEPS; gk++) begin : g_step
		localparam int J = pcr_pkg::DIV_STEPS - 1 - gk;
		logic [pcr_pkg::NUM_W-1:0]  rin;
		logic [pcr_pkg::ROOT_W-1:0] din;
		logic [pcr_pkg::Q_W-1:0]    qin;
		logic [DW-1:0]              dsh;
		if (gk == 0) begin : g_first
			assign rin = num;
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[gk-1];
			assign din = den_s[gk-1];
			assign qin = q_s[gk-1];
		end
		assign dsh = DW'(din) << J;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[gk] <= din;
				if ({1'b0, rin} >= dsh) begin
					rem_s[gk] <= rin - dsh[pcr_pkg::NUM_W-1:0];
					q_s[gk]   <= qin | (pcr_pkg::Q_W'(1) << J);
				end else begin
					rem_s[gk] <= rin;
					q_s[gk]   <= qin;
				end
			end
		end
	end

	assign quo = q_s[pcr_pkg::DIV_STEPS-1];
endmodule

// ===== hw/rtl/particle_circle_reflect_top.sv =====
// Particle against circular container: move, test, reflect, saturate.
// Depends on pcr_pkg, pcr_if, pcr_isqrt, pcr_udiv and the assertion header.
//
// Usage:
//   in_ch carries one particle (position, velocity, time step, container
//   centre) per transfer; out_ch returns the updated position, velocity and
//   hit flag per transfer, in order, one result for each particle.
//   cfg_we/cfg_index/cfg_data write the particle radius (index 0) and
//   container_radius (index 1); other indexes are ignored.
// Timing:
//   From input transfer to result valid the pipeline has 4 stages of
//   move and square, 22 square-root stages, 1 normal setup stage, 17 divider
//   stages and 4 reflect/saturate stages including the output register.
//   Throughput is one particle per cycle while the pipeline is not stalled.
// Reset:
//   All stage valid bits clear; radii return to 5.0 and 100.0 pixels.
// Stall:
//   When out_ch.ready is low with a result waiting, the whole pipeline holds
//   and in_ch.ready drops in the same cycle; nothing is lost or repeated.
module particle_circle_reflect_top (
	input  logic                         clk,
	input  logic                         arst_n,
	pcr_in_if.sink                       in_ch,
	pcr_out_if.source                    out_ch,
	input  logic                         cfg_we,
	input  logic [pcr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pcr_pkg::CFG_W-1:0]    cfg_data
);
`include "particle_circle_reflect_top_assert.svh"

	localparam int DP_W  = pcr_pkg::VEL_W + pcr_pkg::DT_W + 1;
	localparam int PV_W  = pcr_pkg::VEL_W + pcr_pkg::N_W;
	localparam int DOT_W = PV_W + 1;
	localparam int OVP_W = pcr_pkg::N_W + pcr_pkg::OV_W;
	localparam int DV_W  = DOT_W + pcr_pkg::N_W;
	localparam int SQ_W  = 2 * pcr_pkg::DIF_W;

	logic en;

	// configuration
	logic [pcr_pkg::PR_W-1:0] pr_q;
	logic [pcr_pkg::CR_W-1:0] cr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_q <= pcr_pkg::PR_RESET;
			cr_q <= pcr_pkg::CR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcr_pkg::REG_PART_RAD:         pr_q <= cfg_data[pcr_pkg::PR_W-1:0];
				pcr_pkg::REG_CONTAINER_RADIUS: cr_q <= cfg_data[pcr_pkg::CR_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: displacement products
	logic                             vld_s1;
	logic signed [DP_W-1:0]           dpx_s1, dpy_s1;
	logic signed [pcr_pkg::POS_W-1:0] px_s1, py_s1, cx_s1, cy_s1;
	logic signed [pcr_pkg::VEL_W-1:0] vx_s1, vy_s1;

	// stage 2: moved position and offset
	logic                             vld_s2;
	pcr_pkg::carry_t                  c_s2;
	logic signed [DP_W-1:0]           rx2, ry2;
	logic signed [pcr_pkg::MOV_W-1:0] mx2, my2;

	// stage 3: squares
	logic                             vld_s3;
	pcr_pkg::carry_t                  c_s3;
	logic signed [SQ_W-1:0]           sqx_s3, sqy_s3;

	// stage 4: radicand
	logic                             vld_s4;
	pcr_pkg::carry_t                  c_s4;
	logic [pcr_pkg::RAD_W-1:0]        rad_s4;

	// delay alongside the square root
	logic                             vld_sq [pcr_pkg::SQ_STEPS];
	pcr_pkg::carry_t                  c_sq   [pcr_pkg::SQ_STEPS];
	logic [pcr_pkg::ROOT_W-1:0]       root;

	// stage 5: collision test, divider operands
	logic                             vld_s5;
	pcr_pkg::mid_t                    m_s5;
	logic [pcr_pkg::ROOT_W-1:0]       dist_s5;
	logic [pcr_pkg::NUM_W-1:0]        numx_s5, numy_s5;
	pcr_pkg::carry_t                  cq;
	logic [pcr_pkg::DIF_W-1:0]        ax5, ay5;
	logic signed [pcr_pkg::OV_W-1:0]  ov5;

	// delay alongside the dividers
	logic                             vld_dv [pcr_pkg::DIV_STEPS];
	pcr_pkg::mid_t                    m_dv   [pcr_pkg::DIV_STEPS];
	logic [pcr_pkg::Q_W-1:0]          qx, qy;

	// stage 6: normal and velocity products
	logic                             vld_s6;
	pcr_pkg::mid_t                    m_s6;
	logic signed [pcr_pkg::N_W-1:0]   nx_s6, ny_s6;
	logic signed [PV_W-1:0]           pvx_s6, pvy_s6;
	logic signed [pcr_pkg::N_W-1:0]   nx6, ny6;
	pcr_pkg::mid_t                    md;

	// stage 7: dot product, position shift products
	logic                             vld_s7;
	pcr_pkg::mid_t                    m_s7;
	logic signed [pcr_pkg::N_W-1:0]   nx_s7, ny_s7;
	logic signed [DOT_W-1:0]          dot_s7;
	logic signed [OVP_W-1:0]          ovx_s7, ovy_s7;

	// stage 8: velocity change products, corrected position
	logic                             vld_s8;
	logic                             coll_s8;
	logic signed [pcr_pkg::VEL_W-1:0] vx_s8, vy_s8;
	logic signed [DV_W-1:0]           dvx_s8, dvy_s8;
	logic signed [pcr_pkg::PW_W-1:0]  qpx_s8, qpy_s8;
	logic signed [OVP_W-1:0]          sx8, sy8;

	// output register
	logic                             out_vld_q;
	logic [pcr_pkg::POS_W-1:0]        opx_q, opy_q;
	logic [pcr_pkg::VEL_W-1:0]        ovx_q, ovy_q;
	logic                             hit_q;
	logic signed [DV_W-1:0]           tvx, tvy;
	logic signed [pcr_pkg::VW_W-1:0]  fvx, fvy;

	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < pcr_pkg::SQ_STEPS; k++) vld_sq[k] <= 1'b0;
			for (int k = 0; k < pcr_pkg::DIV_STEPS; k++) vld_dv[k] <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_sq[0] <= vld_s4;
			for (int k = 1; k < pcr_pkg::SQ_STEPS; k++) vld_sq[k] <= vld_sq[k-1];
			vld_s5 <= vld_sq[pcr_pkg::SQ_STEPS-1];
			vld_dv[0] <= vld_s5;
			for (int k = 1; k < pcr_pkg::DIV_STEPS; k++) vld_dv[k] <= vld_dv[k-1];
			vld_s6    <= vld_dv[pcr_pkg::DIV_STEPS-1];
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			out_vld_q <= vld_s8;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			dpx_s1 <= DP_W'(in_ch.vel_x) * DP_W'($signed({1'b0, in_ch.time_step}));
			dpy_s1 <= DP_W'(in_ch.vel_y) * DP_W'($signed({1'b0, in_ch.time_step}));
			px_s1  <= in_ch.pos_x;
			py_s1  <= in_ch.pos_y;
			vx_s1  <= in_ch.vel_x;
			vy_s1  <= in_ch.vel_y;
			cx_s1  <= in_ch.center_x;
			cy_s1  <= in_ch.center_y;
		end
	end

	// stage 2: round half up to Q.8
	always_comb begin
		rx2 = (dpx_s1 + DP_W'(1 << 15)) >>> 16;
		ry2 = (dpy_s1 + DP_W'(1 << 15)) >>> 16;
		mx2 = pcr_pkg::MOV_W'(px_s1) + rx2[pcr_pkg::MOV_W-1:0];
		my2 = pcr_pkg::MOV_W'(py_s1) + ry2[pcr_pkg::MOV_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2.px <= mx2;
			c_s2.py <= my2;
			c_s2.vx <= vx_s1;
			c_s2.vy <= vy_s1;
			c_s2.dx <= pcr_pkg::DIF_W'(mx2) - pcr_pkg::DIF_W'(cx_s1);
			c_s2.dy <= pcr_pkg::DIF_W'(my2) - pcr_pkg::DIF_W'(cy_s1);
		end
	end

	// stage 3, 4
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3   <= c_s2;
			sqx_s3 <= c_s2.dx * c_s2.dx;
			sqy_s3 <= c_s2.dy * c_s2.dy;
			c_s4   <= c_s3;
			rad_s4 <= pcr_pkg::RAD_W'(sqx_s3) + pcr_pkg::RAD_W'(sqy_s3);
		end
	end

	pcr_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s4),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			c_sq[0] <= c_s4;
			for (int k = 1; k < pcr_pkg::SQ_STEPS; k++) c_sq[k] <= c_sq[k-1];
		end
	end

	// stage 5
	always_comb begin
		cq  = c_sq[pcr_pkg::SQ_STEPS-1];
		ax5 = cq.dx[pcr_pkg::DIF_W-1] ? pcr_pkg::DIF_W'(-cq.dx) : pcr_pkg::DIF_W'(cq.dx);
		ay5 = cq.dy[pcr_pkg::DIF_W-1] ? pcr_pkg::DIF_W'(-cq.dy) : pcr_pkg::DIF_W'(cq.dy);
		ov5 = $signed(pcr_pkg::OV_W'(root)) + $signed(pcr_pkg::OV_W'(pr_q))
			- $signed(pcr_pkg::OV_W'(cr_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s5.px   <= cq.px;
			m_s5.py   <= cq.py;
			m_s5.vx   <= cq.vx;
			m_s5.vy   <= cq.vy;
			m_s5.ov   <= ov5;
			m_s5.coll <= (root != '0) && (ov5 > 0);
			m_s5.sx   <= cq.dx[pcr_pkg::DIF_W-1];
			m_s5.sy   <= cq.dy[pcr_pkg::DIF_W-1];
			dist_s5   <= root;
			numx_s5   <= (pcr_pkg::NUM_W'(ax5) << 15) + pcr_pkg::NUM_W'(root >> 1);
			numy_s5   <= (pcr_pkg::NUM_W'(ay5) << 15) + pcr_pkg::NUM_W'(root >> 1);
		end
	end

	pcr_udiv u_divx (
		.clk (clk),
		.en  (en),
		.num (numx_s5),
		.den (dist_s5),
		.quo (qx)
	);

	pcr_udiv u_divy (
		.clk (clk),
		.en  (en),
		.num (numy_s5),
		.den (dist_s5),
		.quo (qy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			m_dv[0] <= m_s5;
			for (int k = 1; k < pcr_pkg::DIV_STEPS; k++) m_dv[k] <= m_dv[k-1];
		end
	end

	// stage 6
	always_comb begin
		md  = m_dv[pcr_pkg::DIV_STEPS-1];
		nx6 = md.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		ny6 = md.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s6   <= md;
			nx_s6  <= nx6;
			ny_s6  <= ny6;
			pvx_s6 <= md.vx * nx6;
			pvy_s6 <= md.vy * ny6;
		end
	end

	// stage 7
	always_ff @(posedge clk) begin
		if (en) begin
			m_s7   <= m_s6;
			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
			dot_s7 <= DOT_W'(pvx_s6) + DOT_W'(pvy_s6);
			ovx_s7 <= nx_s6 * m_s6.ov;
			ovy_s7 <= ny_s6 * m_s6.ov;
		end
	end

	// stage 8: position shift rounded half up from Q.23
	always_comb begin
		sx8 = (ovx_s7 + OVP_W'(1 << 14)) >>> 15;
		sy8 = (ovy_s7 + OVP_W'(1 << 14)) >>> 15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coll_s8 <= m_s7.coll;
			vx_s8   <= m_s7.vx;
			vy_s8   <= m_s7.vy;
			dvx_s8  <= dot_s7 * nx_s7;
			dvy_s8  <= dot_s7 * ny_s7;
			qpx_s8  <= m_s7.coll ? pcr_pkg::PW_W'(m_s7.px) - sx8[pcr_pkg::PW_W-1:0]
				: pcr_pkg::PW_W'(m_s7.px);
			qpy_s8  <= m_s7.coll ? pcr_pkg::PW_W'(m_s7.py) - sy8[pcr_pkg::PW_W-1:0]
				: pcr_pkg::PW_W'(m_s7.py);
		end
	end

	// output: 2*dot*n rounded from Q.38 is dot*n rounded from Q.37
	always_comb begin
		tvx = (dvx_s8 + DV_W'(64'sd1 <<< 28)) >>> 29;
		tvy = (dvy_s8 + DV_W'(64'sd1 <<< 28)) >>> 29;
		fvx = coll_s8 ? pcr_pkg::VW_W'(vx_s8) - tvx[pcr_pkg::VW_W-1:0]
			: pcr_pkg::VW_W'(vx_s8);
		fvy = coll_s8 ? pcr_pkg::VW_W'(vy_s8) - tvy[pcr_pkg::VW_W-1:0]
			: pcr_pkg::VW_W'(vy_s8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			opx_q <= pcr_pkg::sat_pos(qpx_s8);
			opy_q <= pcr_pkg::sat_pos(qpy_s8);
			ovx_q <= pcr_pkg::sat_vel(fvx);
			ovy_q <= pcr_pkg::sat_vel(fvy);
			hit_q <= coll_s8;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.new_pos_x = opx_q;
	assign out_ch.new_pos_y = opy_q;
	assign out_ch.new_vel_x = ovx_q;
	assign out_ch.new_vel_y = ovy_q;
	assign out_ch.hit       = hit_q;

	`PCR_ASSERT_NXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_s1,
		"accepted transfer did not enter stage 1")
	`PCR_ASSERT_NXT(a_stall_holds, !en, $stable(vld_s1) && $stable(vld_s5) && $stable(vld_s8),
		"pipeline valid moved during stall")
	`PCR_ASSERT_IMP(a_norm_bound, vld_s6 && m_s6.coll,
		nx_s6 <= 32768 && nx_s6 >= -32768 && ny_s6 <= 32768 && ny_s6 >= -32768,
		"normal component out of unit range")
endmodule
